// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, off during reset
`define PEB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication, off during reset
`define PEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

// File: sv/pebst_pkg.sv
// shared constants, stage types and arithmetic helpers of the emission point boost
package pebst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RAND_FRAC = 12;
    localparam int REG_FRAC  = 16;
    localparam int RAD_SHR   = RAND_FRAC + REG_FRAC - FRAC_BITS;
    localparam int MEAN_SHL  = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
    localparam int MEAN_SHR  = (FRAC_BITS >= REG_FRAC) ? 0 : REG_FRAC - FRAC_BITS;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 8'd1;

    localparam logic signed [31:0] SYM_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] NEG_MAX = 32'sh80000000;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq_stg;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic [31:0] den;
        logic        neg;
        logic        ovf;
    } t_div_stg;

    // one digit of the floor square root
    function automatic t_sq_stg sq_step(input t_sq_stg s, input logic [63:0] b);
        t_sq_stg     o;
        logic [63:0] t;
        t = s.r + b;
        if (s.v >= t) begin
            o.v = s.v - t;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic t_div_stg div_step(input t_div_stg s);
        t_div_stg    o;
        logic [32:0] t;
        logic        q;
        o = s;
        t = {s.rem, s.low[31]};
        q = (t >= {1'b0, s.den});
        o.rem = q ? 32'(t - {1'b0, s.den}) : t[31:0];
        o.low = {s.low[30:0], 1'b0};
        o.quo = {s.quo[30:0], q};
        return o;
    endfunction

    // clamp to the symmetric 32-bit range
    function automatic logic signed [31:0] clamp_sym(input logic signed [47:0] x);
        logic signed [31:0] y;
        if (x > 48'sd2147483647) begin
            y = SYM_MAX;
        end else if (x < -48'sd2147483647) begin
            y = -SYM_MAX;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // magnitude of a symmetric-range value
    function automatic logic [30:0] mag31(input logic signed [31:0] x);
        logic signed [31:0] n;
        n = (x < 0) ? -x : x;
        return n[30:0];
    endfunction

    // signed quotient clamped to the symmetric range
    function automatic logic signed [31:0] sat_sym(input logic [31:0] q, input logic ovf,
                                                   input logic neg);
        logic signed [31:0] m;
        m = (ovf || q[31]) ? SYM_MAX : signed'(q);
        return neg ? -m : m;
    endfunction

    // signed quotient saturated to the full 32-bit range
    function automatic logic signed [31:0] sat_out(input logic [31:0] q, input logic ovf,
                                                   input logic neg);
        logic signed [31:0] y;
        if (!neg) begin
            y = (ovf || q[31]) ? SYM_MAX : signed'(q);
        end else begin
            y = (ovf || q > 32'h80000000) ? NEG_MAX : -signed'(q);
        end
        return y;
    endfunction

endpackage

// File: sv/pebst_isqrt.sv
// pipelined floor square root of a 64-bit value, one digit per stage
module pebst_isqrt import pebst_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    t_sq_stg r_st [0:SQ_STEPS-1];

    // digit stages, stage i tries bit 4^(31-i)
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stg
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_st[i] <= sq_step('{v: i_rad, r: 64'd0}, BIT);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_st[i] <= sq_step(r_st[i-1], BIT);
            end
        end
    end

    assign o_root = r_st[SQ_STEPS-1].r[31:0];

endmodule

// File: sv/pebst_div.sv
// pipelined unsigned divider with sign and overflow sideband, one bit per stage
module pebst_div import pebst_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    input  logic        i_neg,
    output logic [31:0] o_quo,
    output logic        o_ovf,
    output logic        o_neg
);

    t_div_stg r_stg [0:DIV_STEPS];

    // load: high half is the first partial remainder, quotient beyond 32 bits flags overflow
    always_ff @(posedge i_clk) begin
        r_stg[0].rem <= i_num[63:32];
        r_stg[0].low <= i_num[31:0];
        r_stg[0].quo <= '0;
        r_stg[0].den <= i_den;
        r_stg[0].neg <= i_neg;
        r_stg[0].ovf <= (i_num[63:32] >= i_den);
    end

    // quotient bit stages
    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_stg
        always_ff @(posedge i_clk) begin
            r_stg[i] <= div_step(r_stg[i-1]);
        end
    end

    assign o_quo = r_stg[DIV_STEPS].quo;
    assign o_ovf = r_stg[DIV_STEPS].ovf;
    assign o_neg = r_stg[DIV_STEPS].neg;

endmodule

// File: sv/pair_emission_point_boost.sv
// top level: pair momentum, roots, radii and boost of the emission point
// throughput: one item per cycle while not busy, every stage advances each cycle
// the rate is set by the one-digit-per-stage root and divider pipelines
// reset: synchronous active low, clears valid bits and both registers to zero
// busy is high only during reset and the cycle after it; results cannot be held off
`include "assert_macros.svh"
module pair_emission_point_boost import pebst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic signed [31:0]   i_first_px,
    input  logic signed [31:0]   i_first_py,
    input  logic signed [31:0]   i_first_pz,
    input  logic signed [31:0]   i_first_energy,
    input  logic signed [31:0]   i_second_px,
    input  logic signed [31:0]   i_second_py,
    input  logic signed [31:0]   i_second_pz,
    input  logic signed [31:0]   i_second_energy,
    input  logic signed [15:0]   i_rand_out,
    input  logic signed [15:0]   i_rand_side,
    input  logic signed [15:0]   i_rand_long,
    output logic                 o_done,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic signed [31:0]   o_pos_z,
    output logic signed [31:0]   o_pos_t,
    output logic                 o_invalid
);

    typedef struct packed {
        logic               valid;
        logic signed [31:0] apx, apy, apz, ae, bpx, bpy, bpz, be;
        logic signed [15:0] ro, rs, rl;
    } t_s0;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] px, py, pz, e;
        logic signed [40:0] po, ps, pl;
    } t_s1;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] px, py, pz, e, rout, rside, rlong;
        logic [61:0]        e2, pz2, px2, py2;
    } t_s2;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rout, rside, rlong;
        logic [61:0]        d1;
        logic [62:0]        pt2;
    } t_s3;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rout, rside, rlong;
        logic [61:0]        d1, d2;
        logic [62:0]        pt2;
    } t_s4;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rout, rside, rlong;
    } t_side1;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rside, rlong;
        logic [31:0]        mt, m, pt;
        logic [62:0]        nb, ng;
        logic               neg;
    } t_s5;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rside, rlong;
        logic [31:0]        mt, pt;
    } t_side2;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [31:0] px, py, pz, e, rside, rlong, b, g;
        logic [31:0]        mt, pt;
    } t_s6;

    typedef struct packed {
        logic               valid;
        logic               inv;
        logic signed [63:0] b_e, pz_rl, rl_e, pz_b, g_px, rs_py, g_py, rs_px;
        logic [31:0]        mt, pt;
    } t_s7;

    typedef struct packed {
        logic        valid;
        logic        inv;
        logic [63:0] nt, nz, nx, ny;
        logic        gt, gz, gx, gy;
        logic [31:0] mt, pt;
    } t_s8;

    typedef struct packed {
        logic valid;
        logic inv;
    } t_side3;

    logic               r_busy;
    logic [23:0]        r_sigma;
    logic signed [23:0] r_mean;

    t_s0 r_s0, n_s0;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;
    t_s8 r_s8, n_s8;

    t_side1 r_d1 [0:SQ_STEPS-1];
    t_side2 r_d2 [0:DIV_STEPS];
    t_side3 r_d3 [0:DIV_STEPS];

    logic [31:0] w_mt, w_m, w_pt;
    logic [31:0] w_qb, w_qg, w_qt, w_qz, w_qx, w_qy;
    logic        w_ob, w_og, w_ot, w_oz, w_ox, w_oy;
    logic        w_sb, w_sg, w_st, w_sz, w_sx, w_sy;

    logic               r_done, r_inv;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z, r_pos_t;

    // busy only around reset, config always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= '0;
            r_mean  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIGMA: r_sigma <= i_cfg_data;
                REG_MEAN:  r_mean  <= signed'(i_cfg_data);
                default:   ;
            endcase
        end
    end

    // input capture
    always_comb begin
        n_s0.valid = i_start && !r_busy;
        n_s0.apx = i_first_px;
        n_s0.apy = i_first_py;
        n_s0.apz = i_first_pz;
        n_s0.ae  = i_first_energy;
        n_s0.bpx = i_second_px;
        n_s0.bpy = i_second_py;
        n_s0.bpz = i_second_pz;
        n_s0.be  = i_second_energy;
        n_s0.ro  = i_rand_out;
        n_s0.rs  = i_rand_side;
        n_s0.rl  = i_rand_long;
    end

    // pair sums and random scaling
    always_comb begin
        n_s1.valid = r_s0.valid;
        n_s1.px = clamp_sym(48'(r_s0.apx) + 48'(r_s0.bpx));
        n_s1.py = clamp_sym(48'(r_s0.apy) + 48'(r_s0.bpy));
        n_s1.pz = clamp_sym(48'(r_s0.apz) + 48'(r_s0.bpz));
        n_s1.e  = clamp_sym(48'(r_s0.ae) + 48'(r_s0.be));
        n_s1.po = 41'(r_s0.ro) * 41'(signed'({1'b0, r_sigma}));
        n_s1.ps = 41'(r_s0.rs) * 41'(signed'({1'b0, r_sigma}));
        n_s1.pl = 41'(r_s0.rl) * 41'(signed'({1'b0, r_sigma}));
    end

    // squares and radii
    always_comb begin
        logic [30:0]        ax, ay, az, ae;
        logic signed [47:0] mean_al;
        ax = mag31(r_s1.px);
        ay = mag31(r_s1.py);
        az = mag31(r_s1.pz);
        ae = mag31(r_s1.e);
        mean_al = (48'(r_mean) <<< MEAN_SHL) >>> MEAN_SHR;
        n_s2.valid = r_s1.valid;
        n_s2.px = r_s1.px;
        n_s2.py = r_s1.py;
        n_s2.pz = r_s1.pz;
        n_s2.e  = r_s1.e;
        n_s2.e2  = 62'(ae) * 62'(ae);
        n_s2.pz2 = 62'(az) * 62'(az);
        n_s2.px2 = 62'(ax) * 62'(ax);
        n_s2.py2 = 62'(ay) * 62'(ay);
        n_s2.rout  = clamp_sym(48'(r_s1.po >>> RAD_SHR) + mean_al);
        n_s2.rside = clamp_sym(48'(r_s1.ps >>> RAD_SHR));
        n_s2.rlong = clamp_sym(48'(r_s1.pl >>> RAD_SHR));
    end

    // mass differences, first negative check
    always_comb begin
        n_s3.valid = r_s2.valid;
        n_s3.inv   = (r_s2.e2 < r_s2.pz2);
        n_s3.px = r_s2.px;
        n_s3.py = r_s2.py;
        n_s3.pz = r_s2.pz;
        n_s3.e  = r_s2.e;
        n_s3.rout  = r_s2.rout;
        n_s3.rside = r_s2.rside;
        n_s3.rlong = r_s2.rlong;
        n_s3.d1  = r_s2.e2 - r_s2.pz2;
        n_s3.pt2 = {1'b0, r_s2.px2} + {1'b0, r_s2.py2};
    end

    // second negative check
    always_comb begin
        n_s4.valid = r_s3.valid;
        n_s4.inv   = r_s3.inv || ({1'b0, r_s3.d1} < r_s3.pt2);
        n_s4.px = r_s3.px;
        n_s4.py = r_s3.py;
        n_s4.pz = r_s3.pz;
        n_s4.e  = r_s3.e;
        n_s4.rout  = r_s3.rout;
        n_s4.rside = r_s3.rside;
        n_s4.rlong = r_s3.rlong;
        n_s4.d1  = r_s3.d1;
        n_s4.d2  = 62'({1'b0, r_s3.d1} - r_s3.pt2);
        n_s4.pt2 = r_s3.pt2;
    end

    // front stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    // transverse mass, invariant mass and transverse momentum
    pebst_isqrt u_sqrt_mt (.i_clk(i_clk), .i_rad(64'(r_s4.d1)),  .o_root(w_mt));
    pebst_isqrt u_sqrt_m  (.i_clk(i_clk), .i_rad(64'(r_s4.d2)),  .o_root(w_m));
    pebst_isqrt u_sqrt_pt (.i_clk(i_clk), .i_rad(64'(r_s4.pt2)), .o_root(w_pt));

    // sideband alongside the roots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQ_STEPS; i++) begin
                r_d1[i].valid <= 1'b0;
            end
        end else begin
            r_d1[0] <= '{valid: r_s4.valid, inv: r_s4.inv, px: r_s4.px, py: r_s4.py,
                         pz: r_s4.pz, e: r_s4.e, rout: r_s4.rout, rside: r_s4.rside,
                         rlong: r_s4.rlong};
            for (int i = 1; i < SQ_STEPS; i++) begin
                r_d1[i] <= r_d1[i-1];
            end
        end
    end

    // zero divisor check and boost numerators
    always_comb begin
        logic [30:0] arout;
        arout = mag31(r_d1[SQ_STEPS-1].rout);
        n_s5.valid = r_d1[SQ_STEPS-1].valid;
        n_s5.inv   = r_d1[SQ_STEPS-1].inv || (w_m == '0) || (w_pt == '0);
        n_s5.px = r_d1[SQ_STEPS-1].px;
        n_s5.py = r_d1[SQ_STEPS-1].py;
        n_s5.pz = r_d1[SQ_STEPS-1].pz;
        n_s5.e  = r_d1[SQ_STEPS-1].e;
        n_s5.rside = r_d1[SQ_STEPS-1].rside;
        n_s5.rlong = r_d1[SQ_STEPS-1].rlong;
        n_s5.mt = w_mt;
        n_s5.m  = w_m;
        n_s5.pt = w_pt;
        n_s5.nb = 63'(arout) * 63'(w_pt);
        n_s5.ng = 63'(arout) * 63'(w_mt);
        n_s5.neg = r_d1[SQ_STEPS-1].rout[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid <= 1'b0;
        end else begin
            r_s5 <= n_s5;
        end
    end

    // rout*pt/m and rout*mt/m
    pebst_div u_div_b (.i_clk(i_clk), .i_num(64'(r_s5.nb)), .i_den(r_s5.m), .i_neg(r_s5.neg),
                       .o_quo(w_qb), .o_ovf(w_ob), .o_neg(w_sb));
    pebst_div u_div_g (.i_clk(i_clk), .i_num(64'(r_s5.ng)), .i_den(r_s5.m), .i_neg(r_s5.neg),
                       .o_quo(w_qg), .o_ovf(w_og), .o_neg(w_sg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_d2[i].valid <= 1'b0;
            end
        end else begin
            r_d2[0] <= '{valid: r_s5.valid, inv: r_s5.inv, px: r_s5.px, py: r_s5.py,
                         pz: r_s5.pz, e: r_s5.e, rside: r_s5.rside, rlong: r_s5.rlong,
                         mt: r_s5.mt, pt: r_s5.pt};
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
        end
    end

    // clamp the boosted radii
    always_comb begin
        n_s6.valid = r_d2[DIV_STEPS].valid;
        n_s6.inv   = r_d2[DIV_STEPS].inv;
        n_s6.px = r_d2[DIV_STEPS].px;
        n_s6.py = r_d2[DIV_STEPS].py;
        n_s6.pz = r_d2[DIV_STEPS].pz;
        n_s6.e  = r_d2[DIV_STEPS].e;
        n_s6.rside = r_d2[DIV_STEPS].rside;
        n_s6.rlong = r_d2[DIV_STEPS].rlong;
        n_s6.mt = r_d2[DIV_STEPS].mt;
        n_s6.pt = r_d2[DIV_STEPS].pt;
        n_s6.b  = sat_sym(w_qb, w_ob, w_sb);
        n_s6.g  = sat_sym(w_qg, w_og, w_sg);
    end

    // lab frame products
    always_comb begin
        n_s7.valid = r_s6.valid;
        n_s7.inv   = r_s6.inv;
        n_s7.mt    = r_s6.mt;
        n_s7.pt    = r_s6.pt;
        n_s7.b_e   = 64'(r_s6.b) * 64'(r_s6.e);
        n_s7.pz_rl = 64'(r_s6.pz) * 64'(r_s6.rlong);
        n_s7.rl_e  = 64'(r_s6.rlong) * 64'(r_s6.e);
        n_s7.pz_b  = 64'(r_s6.pz) * 64'(r_s6.b);
        n_s7.g_px  = 64'(r_s6.g) * 64'(r_s6.px);
        n_s7.rs_py = 64'(r_s6.rside) * 64'(r_s6.py);
        n_s7.g_py  = 64'(r_s6.g) * 64'(r_s6.py);
        n_s7.rs_px = 64'(r_s6.rside) * 64'(r_s6.px);
    end

    // lab frame numerators as sign and magnitude
    always_comb begin
        logic signed [63:0] st, sz, sx, sy;
        st = r_s7.b_e + r_s7.pz_rl;
        sz = r_s7.rl_e + r_s7.pz_b;
        sx = r_s7.g_px - r_s7.rs_py;
        sy = r_s7.g_py + r_s7.rs_px;
        n_s8.valid = r_s7.valid;
        n_s8.inv   = r_s7.inv;
        n_s8.mt    = r_s7.mt;
        n_s8.pt    = r_s7.pt;
        n_s8.gt = st[63];
        n_s8.gz = sz[63];
        n_s8.gx = sx[63];
        n_s8.gy = sy[63];
        n_s8.nt = st[63] ? unsigned'(-st) : unsigned'(st);
        n_s8.nz = sz[63] ? unsigned'(-sz) : unsigned'(sz);
        n_s8.nx = sx[63] ? unsigned'(-sx) : unsigned'(sx);
        n_s8.ny = sy[63] ? unsigned'(-sy) : unsigned'(sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.valid <= 1'b0;
            r_s7.valid <= 1'b0;
            r_s8.valid <= 1'b0;
        end else begin
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
        end
    end

    // final divisions by mt and pt
    pebst_div u_div_t (.i_clk(i_clk), .i_num(r_s8.nt), .i_den(r_s8.mt), .i_neg(r_s8.gt),
                       .o_quo(w_qt), .o_ovf(w_ot), .o_neg(w_st));
    pebst_div u_div_z (.i_clk(i_clk), .i_num(r_s8.nz), .i_den(r_s8.mt), .i_neg(r_s8.gz),
                       .o_quo(w_qz), .o_ovf(w_oz), .o_neg(w_sz));
    pebst_div u_div_x (.i_clk(i_clk), .i_num(r_s8.nx), .i_den(r_s8.pt), .i_neg(r_s8.gx),
                       .o_quo(w_qx), .o_ovf(w_ox), .o_neg(w_sx));
    pebst_div u_div_y (.i_clk(i_clk), .i_num(r_s8.ny), .i_den(r_s8.pt), .i_neg(r_s8.gy),
                       .o_quo(w_qy), .o_ovf(w_oy), .o_neg(w_sy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_d3[i].valid <= 1'b0;
            end
        end else begin
            r_d3[0] <= '{valid: r_s8.valid, inv: r_s8.inv};
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_d3[i] <= r_d3[i-1];
            end
        end
    end

    // output register, positions forced to zero on an invalid item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_d3[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv   <= r_d3[DIV_STEPS].inv;
        r_pos_t <= r_d3[DIV_STEPS].inv ? '0 : sat_out(w_qt, w_ot, w_st);
        r_pos_z <= r_d3[DIV_STEPS].inv ? '0 : sat_out(w_qz, w_oz, w_sz);
        r_pos_x <= r_d3[DIV_STEPS].inv ? '0 : sat_out(w_qx, w_ox, w_sx);
        r_pos_y <= r_d3[DIV_STEPS].inv ? '0 : sat_out(w_qy, w_oy, w_sy);
    end

    assign o_done    = r_done;
    assign o_invalid = r_inv;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_pos_z   = r_pos_z;
    assign o_pos_t   = r_pos_t;

    // checks
    `PEB_ASSERT_IMPL(a_inv_zero, i_clk, i_rst_n, o_done && o_invalid, o_pos_x == '0 && o_pos_y == '0 && o_pos_z == '0 && o_pos_t == '0)
    `PEB_ASSERT_IMPL(a_root_order, i_clk, i_rst_n, r_d1[SQ_STEPS-1].valid && !r_d1[SQ_STEPS-1].inv, w_m <= w_mt)
    `PEB_ASSERT_NEXT(a_cfg_sigma, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && i_cfg_index == REG_SIGMA, r_sigma == $past(i_cfg_data))

endmodule
